[hw/rtl/adpe_pkg.sv]
package adpe_pkg;

  // Data-processing opcodes, instruction bits 24..21.
  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;

  // Condition codes, instruction bits 31..28.
  localparam logic [3:0] COND_EQ = 4'd0;
  localparam logic [3:0] COND_NE = 4'd1;
  localparam logic [3:0] COND_CS = 4'd2;
  localparam logic [3:0] COND_CC = 4'd3;
  localparam logic [3:0] COND_MI = 4'd4;
  localparam logic [3:0] COND_PL = 4'd5;
  localparam logic [3:0] COND_VS = 4'd6;
  localparam logic [3:0] COND_VC = 4'd7;
  localparam logic [3:0] COND_HI = 4'd8;
  localparam logic [3:0] COND_LS = 4'd9;
  localparam logic [3:0] COND_GE = 4'd10;
  localparam logic [3:0] COND_LT = 4'd11;
  localparam logic [3:0] COND_GT = 4'd12;
  localparam logic [3:0] COND_LE = 4'd13;
  localparam logic [3:0] COND_AL = 4'd14;

  // Shift types, instruction bits 6..5.
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // Bit positions within the NZCV flag nibble.
  localparam int FLAG_N = 3;
  localparam int FLAG_Z = 2;
  localparam int FLAG_C = 1;
  localparam int FLAG_V = 0;

  // Register file write port.
  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [31:0] data;
  } adpe_wr_t;

  // Outcome of executing one instruction.
  typedef struct packed {
    logic        passed;
    logic        undef;
    logic        we;
    logic        upd_flags;
    logic [3:0]  rd;
    logic [31:0] result;
    logic [3:0]  flags;
  } adpe_res_t;

endpackage

[hw/rtl/adpe_regfile.sv]
module adpe_regfile (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [3:0]       rn_addr,
  input  logic [3:0]       rm_addr,
  input  logic [3:0]       rs_addr,
  input  adpe_pkg::adpe_wr_t wr,
  output logic [31:0]      rn_data,
  output logic [31:0]      rm_data,
  output logic [31:0]      rs_data
);

  // Two copies of the register file so that three operands can be read per cycle.
  logic [31:0] mem_a [16];
  logic [31:0] mem_b [16];
  logic [15:0] valid_r;

  logic [31:0] rn_raw_r, rm_raw_r, rs_raw_r;
  logic [31:0] byp_data_r;
  logic [2:0]  hit_r;
  logic [2:0]  zero_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_a[wr.addr] <= wr.data;
      mem_b[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rn_raw_r   <= mem_a[rn_addr];
      rm_raw_r   <= mem_a[rm_addr];
      rs_raw_r   <= mem_b[rs_addr];
      byp_data_r <= wr.data;
    end
  end

  // A write at the same edge as the read is forwarded; an entry never
  // written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= '0;
      zero_r  <= '0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r[0]  <= wr.en && (wr.addr == rn_addr);
        hit_r[1]  <= wr.en && (wr.addr == rm_addr);
        hit_r[2]  <= wr.en && (wr.addr == rs_addr);
        zero_r[0] <= !valid_r[rn_addr];
        zero_r[1] <= !valid_r[rm_addr];
        zero_r[2] <= !valid_r[rs_addr];
      end
    end
  end

  assign rn_data = hit_r[0] ? byp_data_r : (zero_r[0] ? '0 : rn_raw_r);
  assign rm_data = hit_r[1] ? byp_data_r : (zero_r[1] ? '0 : rm_raw_r);
  assign rs_data = hit_r[2] ? byp_data_r : (zero_r[2] ? '0 : rs_raw_r);

endmodule

[hw/rtl/adpe_exec.sv]
module adpe_exec (
  input  logic [31:0]       instr,
  input  logic [31:0]       rn_data,
  input  logic [31:0]       rm_data,
  input  logic [31:0]       rs_data,
  input  logic [3:0]        flags,
  output adpe_pkg::adpe_res_t res
);

  logic               n, z, c, v, cin, passed;
  logic [7:0]         amt;
  logic [4:0]         amt_lo, rot;
  logic               ge32, eq32;
  logic [32:0]        lsl33, lsr33;
  logic signed [32:0] asr33;
  logic [63:0]        ror64, imm64;
  logic [31:0]        shifted, op2, alu;
  logic               sh_c, op_c, carry, undef, we;
  logic [32:0]        sum33, sub33, rsb33;

  assign n   = flags[adpe_pkg::FLAG_N];
  assign z   = flags[adpe_pkg::FLAG_Z];
  assign c   = flags[adpe_pkg::FLAG_C];
  assign v   = flags[adpe_pkg::FLAG_V];
  assign cin = c;

  always_comb begin
    case (instr[31:28])
      adpe_pkg::COND_EQ: passed = z;
      adpe_pkg::COND_NE: passed = !z;
      adpe_pkg::COND_CS: passed = c;
      adpe_pkg::COND_CC: passed = !c;
      adpe_pkg::COND_MI: passed = n;
      adpe_pkg::COND_PL: passed = !n;
      adpe_pkg::COND_VS: passed = v;
      adpe_pkg::COND_VC: passed = !v;
      adpe_pkg::COND_HI: passed = c && !z;
      adpe_pkg::COND_LS: passed = !c || z;
      adpe_pkg::COND_GE: passed = (n == v);
      adpe_pkg::COND_LT: passed = (n != v);
      adpe_pkg::COND_GT: passed = !z && (n == v);
      adpe_pkg::COND_LE: passed = z || (n != v);
      adpe_pkg::COND_AL: passed = 1'b1;
      default:           passed = 1'b0;
    endcase
  end

  // Barrel shifter for the register form of operand 2.
  assign amt    = instr[4] ? rs_data[7:0] : {3'b000, instr[11:7]};
  assign amt_lo = amt[4:0];
  assign ge32   = |amt[7:5];
  assign eq32   = (amt == 8'd32);
  assign lsl33  = {1'b0, rm_data} << amt_lo;
  assign lsr33  = {rm_data, 1'b0} >> amt_lo;
  assign asr33  = $signed({rm_data, 1'b0}) >>> amt_lo;
  assign ror64  = {rm_data, rm_data} >> amt_lo;

  always_comb begin
    case (instr[6:5])
      adpe_pkg::SH_LSL: begin
        if (!ge32) begin
          shifted = lsl33[31:0];
          sh_c    = lsl33[32];
        end else begin
          shifted = '0;
          sh_c    = eq32 && rm_data[0];
        end
      end
      adpe_pkg::SH_LSR: begin
        if (!ge32) begin
          shifted = lsr33[32:1];
          sh_c    = lsr33[0];
        end else begin
          shifted = '0;
          sh_c    = eq32 && rm_data[31];
        end
      end
      adpe_pkg::SH_ASR: begin
        if (!ge32) begin
          shifted = asr33[32:1];
          sh_c    = asr33[0];
        end else begin
          shifted = {32{rm_data[31]}};
          sh_c    = rm_data[31];
        end
      end
      default: begin
        shifted = ror64[31:0];
        sh_c    = ror64[31];
      end
    endcase
    if (amt == 8'd0) begin
      shifted = rm_data;
      sh_c    = cin;
    end
  end

  // Rotated 8-bit immediate.
  assign rot   = {instr[11:8], 1'b0};
  assign imm64 = {24'd0, instr[7:0], 24'd0, instr[7:0]} >> rot;

  always_comb begin
    if (instr[25]) begin
      op2  = imm64[31:0];
      op_c = (rot == 5'd0) ? cin : imm64[31];
    end else begin
      op2  = shifted;
      op_c = sh_c;
    end
  end

  assign sum33 = {1'b0, rn_data} + {1'b0, op2};
  assign sub33 = {1'b0, rn_data} - {1'b0, op2};
  assign rsb33 = {1'b0, op2} - {1'b0, rn_data};

  always_comb begin
    alu   = '0;
    carry = op_c;
    undef = 1'b0;
    we    = 1'b0;
    case (instr[24:21])
      adpe_pkg::OP_AND: begin alu = rn_data & op2; we = 1'b1; end
      adpe_pkg::OP_EOR: begin alu = rn_data ^ op2; we = 1'b1; end
      adpe_pkg::OP_SUB: begin alu = sub33[31:0]; carry = !sub33[32]; we = 1'b1; end
      adpe_pkg::OP_RSB: begin alu = rsb33[31:0]; carry = !rsb33[32]; we = 1'b1; end
      adpe_pkg::OP_ADD: begin alu = sum33[31:0]; carry = sum33[32]; we = 1'b1; end
      adpe_pkg::OP_TST: alu = rn_data & op2;
      adpe_pkg::OP_TEQ: alu = rn_data ^ op2;
      adpe_pkg::OP_CMP: begin alu = sub33[31:0]; carry = !sub33[32]; end
      adpe_pkg::OP_ORR: begin alu = rn_data | op2; we = 1'b1; end
      adpe_pkg::OP_MOV: begin alu = op2; we = 1'b1; end
      default:          undef = 1'b1;
    endcase
  end

  always_comb begin
    res.passed    = passed;
    res.undef     = passed && undef;
    res.we        = passed && !undef && we;
    res.upd_flags = passed && !undef && instr[20];
    res.rd        = instr[15:12];
    res.result    = (passed && !undef) ? alu : '0;
    res.flags     = flags;
    if (res.upd_flags) begin
      res.flags[adpe_pkg::FLAG_N] = alu[31];
      res.flags[adpe_pkg::FLAG_Z] = (alu == 32'd0);
      res.flags[adpe_pkg::FLAG_C] = carry;
    end
  end

endmodule

[hw/rtl/arm_data_processing_execute.sv]
// Execute stage for 32-bit data-processing instructions.
//
// The input channel (in_valid, in_stall, in_instruction) takes one
// instruction word per handshake. The result channel (out_valid, out_stall
// and the out_ result fields) returns exactly one word per instruction, in
// order: condition outcome, undefined flag, write enable, Rd, ALU result and
// the NZCV flags after the instruction.
//
// The accepting edge registers the instruction into the execute stage, and the
// result word is registered into the output register when that stage advances.
// The register file is held in synchronous memories: the operand read is issued
// at the accepting edge, and execute plus write-back happen in the execute stage.
// A write on the same edge as a read is forwarded, so unless the receiver stalls,
// one instruction is accepted every cycle with no bubbles, even back-to-back
// dependent instructions.
// Reset (rst_n low, synchronous) clears the flags, empties the pipeline and
// marks every register as never written, so all registers read as zero.
// When the receiver stalls and the output register is full, the execute
// stage holds its instruction and in_stall rises in the same cycle.
module arm_data_processing_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_condition_passed,
  output logic        out_undefined_op,
  output logic        out_write_enable,
  output logic [3:0]  out_dest_reg,
  output logic [31:0] out_result_value,
  output logic [3:0]  out_flags_nzcv
);

  logic               accept, advance;
  logic               s1_valid_r, s1_valid_nxt;
  logic [31:0]        s1_instr_r;
  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         flags_r;
  logic [31:0]        rn_data, rm_data, rs_data;
  adpe_pkg::adpe_wr_t wr;
  adpe_pkg::adpe_res_t res;
  adpe_pkg::adpe_res_t out_r;

  // The execute stage moves on when the output register is free or drains.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  // Operand reads are issued straight from the incoming word.
  adpe_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rn_addr (in_instruction[19:16]),
    .rm_addr (in_instruction[3:0]),
    .rs_addr (in_instruction[11:8]),
    .wr      (wr),
    .rn_data (rn_data),
    .rm_data (rm_data),
    .rs_data (rs_data)
  );

  adpe_exec u_exec (
    .instr   (s1_instr_r),
    .rn_data (rn_data),
    .rm_data (rm_data),
    .rs_data (rs_data),
    .flags   (flags_r),
    .res     (res)
  );

  assign wr.en   = advance && res.we;
  assign wr.addr = res.rd;
  assign wr.data = res.result;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance && res.upd_flags) begin
        flags_r <= res.flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr_r <= in_instruction;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_condition_passed = out_r.passed;
  assign out_undefined_op     = out_r.undef;
  assign out_write_enable     = out_r.we;
  assign out_dest_reg         = out_r.rd;
  assign out_result_value     = out_r.result;
  assign out_flags_nzcv       = out_r.flags;

  // The input side is only held back by a full execute stage.
  a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with an empty execute stage");

  // A word that writes a register must have passed and be defined.
  a_write_is_defined: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.we |-> out_r.passed && !out_r.undef)
    else $error("register write reported for a skipped or undefined word");

  // Undefined operations report a zero result.
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.undef |-> out_r.result == 32'd0)
    else $error("undefined operation produced a nonzero result");

  // While the execute stage is held, the flags must not move.
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> $stable(flags_r))
    else $error("flags changed while execute stage was held");

endmodule
